// ===== src/acd_pkg.sv =====
// Package for the accessory coil driver: request struct, status struct,
// register indexes, field positions and reset constants.
// No dependencies.
package acd_pkg;

  localparam int OUT_BITS       = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 15;
  localparam int ADDR_BITS      = 8;
  localparam int TIMEOUT_BITS   = 15;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_OWN_ADDRESS   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIGNAL_MODE   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT_TICKS = 2'd2;

  // Request kinds
  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Data byte layout
  localparam int COIL_LSB = 1;
  localparam int COIL_MSB = 3;
  localparam int EN_BIT   = 4;

  localparam logic [OUT_BITS-1:0]     RED_PATTERN       = 8'h55;
  localparam logic [ADDR_BITS-1:0]    OWN_ADDRESS_RESET = 8'h01;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET     = 15'd500;

  typedef struct packed {
    logic                 req_type;
    logic [ADDR_BITS-1:0] pkt_address;
    logic [7:0]           pkt_data;
  } acd_req_t;

  typedef struct packed {
    logic                signal_mode;
    logic [OUT_BITS-1:0] levels;
  } acd_status_t;

endpackage

// ===== src/acd_in_stage.sv =====
// Input register of the accessory coil driver.
// Holds one request until the coil bank takes it. Uses acd_pkg.
module acd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  acd_pkg::acd_req_t req_in,
  input  logic              advance,
  output logic              held_valid,
  output acd_pkg::acd_req_t req_held
);
  import acd_pkg::*;

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_held <= req_in;
    end
  end

endmodule

// ===== src/acd_coil_bank.sv =====
// Coil bank: configuration registers, tick counter, per-coil start time and
// on state, output levels, and the next-state update for one request.
// Uses acd_pkg.
module acd_coil_bank #(
  parameter int NUM_OUTPUTS = 8,
  parameter int TIME_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 advance,
  input  acd_pkg::acd_req_t                    req,
  input  logic                                 cfg_write,
  input  logic [acd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [acd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic [acd_pkg::OUT_BITS-1:0]         result_levels,
  output acd_pkg::acd_status_t                 status
);
  import acd_pkg::*;

  localparam int CMP_BITS = (TIME_BITS > TIMEOUT_BITS) ? TIME_BITS : TIMEOUT_BITS;

  logic [ADDR_BITS-1:0]    own_address;
  logic                    signal_mode;
  logic [TIMEOUT_BITS-1:0] timeout_ticks;

  logic [TIME_BITS-1:0]   ms_counter;
  logic [TIME_BITS-1:0]   ms_counter_next;
  logic [TIME_BITS-1:0]   counter_inc;
  logic [TIME_BITS-1:0]   coil_start      [NUM_OUTPUTS];
  logic [TIME_BITS-1:0]   coil_start_next [NUM_OUTPUTS];
  logic [TIME_BITS-1:0]   elapsed         [NUM_OUTPUTS];
  logic [NUM_OUTPUTS-1:0] coil_active;
  logic [NUM_OUTPUTS-1:0] coil_active_next;
  logic [NUM_OUTPUTS-1:0] level_reg;
  logic [NUM_OUTPUTS-1:0] level_reg_next;
  logic [NUM_OUTPUTS-1:0] expired;

  logic [2:0] coil;
  logic [2:0] partner;
  logic       en;
  logic       coil_ok;
  logic       hit;

  assign coil    = req.pkt_data[COIL_MSB:COIL_LSB];
  assign partner = coil ^ 3'd1;
  assign en      = req.pkt_data[EN_BIT];
  assign coil_ok = {1'b0, coil} < 4'(NUM_OUTPUTS);
  assign hit     = (req.req_type == REQ_PACKET) && (req.pkt_address == own_address) && coil_ok;

  // Timeouts are measured against the count after this tick
  assign counter_inc = ms_counter + TIME_BITS'(1);

  always_comb begin
    for (int i = 0; i < NUM_OUTPUTS; i++) begin
      elapsed[i] = counter_inc - coil_start[i];
      expired[i] = coil_active[i] && (CMP_BITS'(elapsed[i]) > CMP_BITS'(timeout_ticks));
    end
  end

  always_comb begin
    ms_counter_next  = ms_counter;
    coil_active_next = coil_active;
    level_reg_next   = level_reg;
    for (int i = 0; i < NUM_OUTPUTS; i++) begin
      coil_start_next[i] = coil_start[i];
    end
    if (advance) begin
      if (req.req_type == REQ_TICK) begin
        ms_counter_next = counter_inc;
        if (!signal_mode) begin
          for (int i = 0; i < NUM_OUTPUTS; i++) begin
            if (expired[i]) begin
              coil_active_next[i] = 1'b0;
              level_reg_next[i]   = 1'b0;
            end
          end
        end
      end else if (hit) begin
        for (int i = 0; i < NUM_OUTPUTS; i++) begin
          if (coil == 3'(i)) begin
            coil_start_next[i]  = ms_counter;
            coil_active_next[i] = en;
            level_reg_next[i]   = signal_mode ? 1'b1 : en;
          end else if (signal_mode && partner == 3'(i)) begin
            // clear the other light of the pair
            level_reg_next[i] = 1'b0;
          end
        end
      end
    end
  end

  assign result_levels      = OUT_BITS'(level_reg_next);
  assign status.signal_mode = signal_mode;
  assign status.levels      = OUT_BITS'(level_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address   <= OWN_ADDRESS_RESET;
      signal_mode   <= 1'b0;
      timeout_ticks <= TIMEOUT_RESET;
      ms_counter    <= '0;
      coil_active   <= '0;
      level_reg     <= '0;
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        coil_start[i] <= '0;
      end
    end else begin
      ms_counter  <= ms_counter_next;
      coil_active <= coil_active_next;
      level_reg   <= level_reg_next;
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        coil_start[i] <= coil_start_next[i];
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_OWN_ADDRESS: begin
            own_address <= cfg_data[ADDR_BITS-1:0];
          end
          REG_SIGNAL_MODE: begin
            // every mode write drops all coils and restarts the lights
            signal_mode <= cfg_data[0];
            coil_active <= '0;
            level_reg   <= cfg_data[0] ? RED_PATTERN[NUM_OUTPUTS-1:0] : '0;
          end
          REG_TIMEOUT_TICKS: begin
            timeout_ticks <= cfg_data[TIMEOUT_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== src/acd_out_stage.sv =====
// Result register of the accessory coil driver.
// Holds the output levels until the consumer takes them. Uses acd_pkg.
module acd_out_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [acd_pkg::OUT_BITS-1:0] levels_in,
  output logic                         can_load,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [acd_pkg::OUT_BITS-1:0] out_levels
);
  import acd_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_levels <= levels_in;
    end
  end

endmodule

// ===== src/accessory_coil_driver_core.sv =====
// Top level of the accessory coil driver: input register, coil bank and
// result register. Uses acd_pkg, acd_in_stage, acd_coil_bank, acd_out_stage.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------
//   request  | in_valid / in_ready    | req_type, pkt_address, pkt_data
//   result   | out_valid / out_ready  | out_levels
//   config   | cfg_write              | cfg_index, cfg_data
//
// One request per cycle while the result is taken; a request passes the input register, then the result register.
// The coil bank updates all coils in parallel, with one
// subtract and compare per coil on a tick.
// Reset (rst, synchronous) empties both registers and loads the register
// defaults; outputs start all off in turnout mode.
// A stalled result holds the pipe; one request still waits in the input register.
module accessory_coil_driver_core #(
  parameter int NUM_OUTPUTS = 8,
  parameter int TIME_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 req_type,
  input  logic [7:0]                           pkt_address,
  input  logic [7:0]                           pkt_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [acd_pkg::OUT_BITS-1:0]         out_levels,
  input  logic                                 cfg_write,
  input  logic [acd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [acd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import acd_pkg::*;

  localparam logic [OUT_BITS-1:0] OUT_MASK = OUT_BITS'((1 << NUM_OUTPUTS) - 1);

  acd_req_t            req_in;
  acd_req_t            req_held;
  acd_status_t         status;
  logic                held_valid;
  logic                advance;
  logic                can_load;
  logic [OUT_BITS-1:0] result_levels;

  assign req_in.req_type    = req_type;
  assign req_in.pkt_address = pkt_address;
  assign req_in.pkt_data    = pkt_data;

  assign advance = held_valid && can_load;

  acd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_in     (req_in),
    .advance    (advance),
    .held_valid (held_valid),
    .req_held   (req_held)
  );

  acd_coil_bank #(
    .NUM_OUTPUTS (NUM_OUTPUTS),
    .TIME_BITS   (TIME_BITS)
  ) u_coil_bank (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .req           (req_held),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_levels (result_levels),
    .status        (status)
  );

  acd_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .levels_in  (result_levels),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_levels (out_levels)
  );

  // Outputs beyond the fitted ones stay low
  a_unused_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_levels & ~OUT_MASK) == '0))
    else $error("out_levels drives an output that is not fitted");

  // In signal mode a red and its green are never lit together
  a_pair_exclusive: assert property (@(posedge clk) disable iff (rst)
    status.signal_mode |-> ((status.levels & (status.levels >> 1) & RED_PATTERN) == '0))
    else $error("both lights of a signal pair are lit");

  // A full pipe with a stalled result accepts nothing
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (held_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while the pipe is full and stalled");

  // A transfer in with an empty pipe yields a result through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !held_valid && !out_valid) |=> ##1 out_valid)
    else $error("result missing after a transfer in");

endmodule
